### sv/swmf_pkg.sv
`default_nettype none
package swmf_pkg;

  localparam int MaxWindowDef   = 16;
  localparam int SampleWidthDef = 24;
  localparam int CfgWidth       = 5;
  localparam int WinReset       = 5;

  typedef struct packed {
    logic start;
    logic full;
    logic res_free;
  } swmf_job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swmf_stat_t;

endpackage
`default_nettype wire

### sv/swmf_ram.sv
`default_nettype none
module swmf_ram #(
  parameter int ADDR_W = 4,
  parameter int WIDTH  = 24
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [(1<<ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/swmf_merge.sv
`default_nettype none
module swmf_merge import swmf_pkg::*; #(
  parameter int MAX_WINDOW   = MaxWindowDef,
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire swmf_job_t                      job,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0] n_old,
  input  wire logic signed [SAMPLE_WIDTH-1:0] new_sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0] old_sample,
  output swmf_stat_t                          stat,
  output logic signed [SAMPLE_WIDTH-1:0]      median
);

  localparam int CNT_W = $clog2(MAX_WINDOW+1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic                           bank_r, bank_nxt;
  logic [CNT_W-1:0]               rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]               w_cnt_r, w_cnt_nxt;
  logic [CNT_W-1:0]               n_old_r;
  logic [CNT_W-1:0]               half_r;
  logic [CNT_W-1:0]               n_new;
  logic                           xv_r, xv_nxt;
  logic                           hv_r, hv_nxt;
  logic                           ins_r, ins_nxt;
  logic                           rem_r, rem_nxt;
  logic                           first_r;
  logic signed [SAMPLE_WIDTH-1:0] h_r, h_nxt;
  logic signed [SAMPLE_WIDTH-1:0] new_r;
  logic signed [SAMPLE_WIDTH-1:0] old_r;
  logic signed [SAMPLE_WIDTH-1:0] med_r, med_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] head;
  logic [SAMPLE_WIDTH-1:0]        rdata;
  logic                           rd_en;
  logic                           done_src;
  logic                           drop;
  logic                           xa;
  logic                           have_head;
  logic                           take_new;
  logic                           wr_en;
  logic signed [SAMPLE_WIDTH-1:0] wr_data;
  logic [IDX_W:0]                 raddr;
  logic [IDX_W:0]                 waddr;

  swmf_ram #(
    .ADDR_W (IDX_W + 1),
    .WIDTH  (SAMPLE_WIDTH)
  ) u_sort_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_new = job.full ? n_old : n_old + 1'b1;
  assign x     = rdata;
  assign raddr = {bank_r, rd_cnt_r[IDX_W-1:0]};
  assign waddr = {~bank_r, w_cnt_r[IDX_W-1:0]};

  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    rd_cnt_nxt = rd_cnt_r;
    w_cnt_nxt  = w_cnt_r;
    xv_nxt     = 1'b0;
    hv_nxt     = hv_r;
    h_nxt      = h_r;
    ins_nxt    = ins_r;
    rem_nxt    = rem_r;
    med_nxt    = med_r;
    wr_en      = 1'b0;
    wr_data    = new_r;
    rd_en      = (rd_cnt_r < n_old_r);
    done_src   = (rd_cnt_r == n_old_r) && !xv_r;
    drop       = xv_r && rem_r && (x == old_r);
    xa         = xv_r && !drop;
    head       = hv_r ? h_r : x;
    have_head  = hv_r || xa;
    take_new   = !ins_r && (have_head ? (new_r <= head) : done_src);
    unique case (state_r)
      S_IDLE: begin
        if (job.start) begin
          state_nxt  = S_RUN;
          rd_cnt_nxt = '0;
          w_cnt_nxt  = '0;
          hv_nxt     = 1'b0;
          ins_nxt    = 1'b0;
          rem_nxt    = job.full;
        end
      end
      S_RUN: begin
        if (drop) begin
          rem_nxt = 1'b0;
        end
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          xv_nxt     = 1'b1;
        end
        if (take_new) begin
          wr_en   = 1'b1;
          wr_data = new_r;
          ins_nxt = 1'b1;
          hv_nxt  = hv_r || xa;
          h_nxt   = hv_r ? h_r : x;
        end else if (have_head) begin
          wr_en   = 1'b1;
          wr_data = head;
          hv_nxt  = hv_r && xa;
          h_nxt   = x;
        end
        if (wr_en) begin
          w_cnt_nxt = w_cnt_r + 1'b1;
          if (w_cnt_r == half_r) begin
            med_nxt = wr_data;
          end
        end
        if (done_src && !hv_r && ins_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (job.res_free) begin
          state_nxt = S_IDLE;
          bank_nxt  = ~bank_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      xv_r    <= 1'b0;
      hv_r    <= 1'b0;
      ins_r   <= 1'b0;
      rem_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      xv_r    <= xv_nxt;
      hv_r    <= hv_nxt;
      ins_r   <= ins_nxt;
      rem_r   <= rem_nxt;
      first_r <= (state_r == S_IDLE) && job.start;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r <= rd_cnt_nxt;
    w_cnt_r  <= w_cnt_nxt;
    h_r      <= h_nxt;
    med_r    <= med_nxt;
    if ((state_r == S_IDLE) && job.start) begin
      n_old_r <= n_old;
      half_r  <= n_new >> 1;
      new_r   <= new_sample;
    end
    if (first_r) begin
      old_r <= old_sample;
    end
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_FIN);
  assign median    = med_r;

endmodule
`default_nettype wire

### sv/sliding_window_median_filter.sv
// Running median filter over a window of the most recent signed samples.
// Each input beat on in_valid/in_stall carries one sample and produces
// exactly one output beat on out_valid/out_stall with the median and a
// flag that is set once the window holds window_size samples.
// The samples sit in a ring memory, and a second memory holds them in
// sorted order in two banks. Each item streams the sorted bank through
// one compare per cycle, drops the sample that leaves the window, inserts
// the new one into the other bank and picks the middle element on the way.
// An item streams every sample in the window through the sorted memory's
// registered read port. One item is in work at a time, and in_stall is
// high while it is, so no new beat is taken before the last item has left
// the merge. The result waits in an output register; the next item is
// taken while it waits, but a finished item holds in the merge until that
// register is empty or the receiver drops stall. Reset and any write on
// cfg_we empty the window and clear the pointers; the window size returns
// to 5, or MAX_WINDOW if less, at reset. No clearing pass is needed.
`default_nettype none
module sliding_window_median_filter import swmf_pkg::*; #(
  parameter int MAX_WINDOW   = MaxWindowDef,
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CfgWidth-1:0]            cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_median,
  output logic                                out_ready_res
);

  localparam int CNT_W   = $clog2(MAX_WINDOW+1);
  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_RST = (WinReset > MAX_WINDOW) ? MAX_WINDOW : WinReset;

  logic [CNT_W-1:0]               win_r;
  logic [CNT_W-1:0]               fill_r, fill_nxt;
  logic [IDX_W-1:0]               wp_r, wp_nxt;
  logic [CNT_W-1:0]               wp_inc;
  logic [CNT_W-1:0]               win_cfg;
  logic                           ready_job_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_median_r;
  logic                           out_ready_r;
  logic                           accept;
  logic                           res_free;
  logic [SAMPLE_WIDTH-1:0]        old_raw;
  logic signed [SAMPLE_WIDTH-1:0] med;
  swmf_job_t                      job;
  swmf_stat_t                     stat;

  assign accept   = in_valid && !stat.busy;
  assign in_stall = stat.busy;
  assign res_free = !out_valid_r || !out_stall;

  assign wp_inc   = CNT_W'(wp_r) + 1'b1;
  assign wp_nxt   = (wp_inc >= win_r) ? '0 : wp_inc[IDX_W-1:0];
  assign fill_nxt = (fill_r < win_r) ? fill_r + 1'b1 : win_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      win_cfg = CNT_W'(1);
    end else if (32'(cfg_wdata) > MAX_WINDOW) begin
      win_cfg = CNT_W'(MAX_WINDOW);
    end else begin
      win_cfg = CNT_W'(cfg_wdata);
    end
  end

  assign job.start    = accept;
  assign job.full     = (fill_r == win_r);
  assign job.res_free = res_free;

  swmf_ram #(
    .ADDR_W (IDX_W),
    .WIDTH  (SAMPLE_WIDTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (in_sample),
    .raddr (wp_r),
    .rdata (old_raw)
  );

  swmf_merge #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .n_old      (fill_r),
    .new_sample (in_sample),
    .old_sample (old_raw),
    .stat       (stat),
    .median     (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= CNT_W'(WIN_RST);
      fill_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r  <= win_cfg;
        fill_r <= '0;
        wp_r   <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
      end
      if (stat.done && res_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ready_job_r <= (fill_nxt == win_r);
    end
    if (stat.done && res_free) begin
      out_median_r <= med;
      out_ready_r  <= ready_job_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_median    = out_median_r;
  assign out_ready_res = out_ready_r;

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count exceeds window size");

  a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wp_r) < win_r)
    else $error("write pointer outside window");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("accepted beat did not start work");

  a_result_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(stat.done))
    else $error("result loaded without finished item");

endmodule
`default_nettype wire
